/* hdl/ddfg_pkg.sv */
package ddfg_pkg;

   localparam int NUM_DIGITS = 6;
   localparam int DIGIT_LIMIT = 10 ** NUM_DIGITS - 1;
   localparam int BIN_WIDTH = $clog2(DIGIT_LIMIT + 1);
   localparam int BCD_WIDTH = 4 * NUM_DIGITS;
   localparam int CNT_WIDTH = $clog2(BIN_WIDTH + 1);

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_SHOW  = 2'd1,
      OP_RANGE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [3:0] REG_LEDS      = 4'h7;
   localparam logic [3:0] REG_DECODE    = 4'h9;
   localparam logic [3:0] REG_INTENSITY = 4'hA;
   localparam logic [3:0] REG_SCANLIM   = 4'hB;
   localparam logic [3:0] REG_POWER     = 4'hC;

   localparam logic [7:0] DATA_DECODE  = 8'h3F;
   localparam logic [7:0] DATA_SCANLIM = 8'h06;
   localparam logic [7:0] DATA_POWER   = 8'h01;

   localparam logic [3:0] CODE_BLANK = 4'hF;
   localparam logic [3:0] CODE_H     = 4'hC;
   localparam logic [3:0] CODE_E     = 4'hB;
   localparam logic [3:0] CODE_L     = 4'hD;
   localparam logic [3:0] CODE_P     = 4'hE;

   localparam logic [7:0] LED_HZ  = 8'h10;
   localparam logic [7:0] LED_KHZ = 8'h40;
   localparam logic [7:0] LED_MHZ = 8'h20;

   localparam logic [3:0] INTENSITY_RESET = 4'd8;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0] reg_address;
      logic [7:0] reg_data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic pop;
   } conv_ctl_type;

   typedef struct packed {
      logic       done;
      logic [3:0] digit;
      logic       rest_zero;
   } conv_sts_type;

endpackage

/* hdl/ddfg_bcd_conv.sv */
module ddfg_bcd_conv
   import ddfg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  conv_ctl_type         ctl,
   input  logic [BIN_WIDTH-1:0] bin_value,
   output conv_sts_type         sts
);

   logic [BIN_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0] bcd_ff, bcd_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [BCD_WIDTH-1:0] adjusted;

   // shift-and-add-3: each digit of five or more is corrected before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (ctl.load) begin
         bin_in = bin_value;
         bcd_in = '0;
         cnt_in = CNT_WIDTH'(BIN_WIDTH);
      end else if (cnt_ff != '0) begin
         bcd_in = {adjusted[BCD_WIDTH-2:0], bin_ff[BIN_WIDTH-1]};
         bin_in = {bin_ff[BIN_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end else if (ctl.pop) begin
         bcd_in = bcd_ff >> 4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign sts.done      = (cnt_ff == '0);
   assign sts.digit     = bcd_ff[3:0];
   assign sts.rest_zero = ((bcd_ff >> 4) == '0);

endmodule

/* hdl/decimal_display_frame_generator_top.sv */
// latency: a unit range word is on the outputs in the cycle after start; other runs first enter
//   S_INIT or S_BLANK, and a number in range first goes through the bit-serial conversion in S_CONV
// throughput: one frame per cycle once a run is past the conversion, up to 12 frames a command
// busy drops with the last frame; a command can be taken in that same cycle
// the result strobe cannot be held off by the receiver
// reset: synchronous, active high; idle, no strobe, intensity back to 8
module decimal_display_frame_generator_top
   import ddfg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_CONV,
      S_BLANK,
      S_DIGIT,
      S_HELP
   } state_type;

   localparam logic [1:0] HELP_FIRST = (NUM_DIGITS >= 4) ? 2'd0 : 2'(4 - NUM_DIGITS);
   localparam logic [3:0] HELP_BASE  = 4'(NUM_DIGITS - 3);
   localparam logic [3:0] TOP_DIGIT  = 4'(NUM_DIGITS);

   state_type    state_ff, state_in;
   logic [3:0]   idx_ff, idx_in;
   logic [1:0]   k_ff, k_in;
   logic         help_ff, help_in;
   logic         strobe_ff, strobe_in;
   rsp_type      rsp_ff, rsp_in;
   logic [3:0]   intensity_ff;
   logic         in_range;
   conv_ctl_type conv_ctl;
   conv_sts_type conv_sts;

   function automatic logic [3:0] help_code(input logic [1:0] k);
      logic [3:0] code;
      unique case (k)
         2'd0:    code = CODE_H;
         2'd1:    code = CODE_E;
         2'd2:    code = CODE_L;
         default: code = CODE_P;
      endcase
      return code;
   endfunction

   ddfg_bcd_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .ctl       (conv_ctl),
      .bin_value (req_data.value[BIN_WIDTH-1:0]),
      .sts       (conv_sts)
   );

   assign in_range = ($unsigned(req_data.value) <= 32'(DIGIT_LIMIT));

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      help_in   = help_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      conv_ctl  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_data.operation)
                  OP_INIT: begin
                     k_in     = 2'd0;
                     state_in = S_INIT;
                  end
                  OP_SHOW: begin
                     if (in_range) begin
                        conv_ctl.load = 1'b1;
                        help_in       = 1'b0;
                        state_in      = S_CONV;
                     end else begin
                        help_in  = 1'b1;
                        idx_in   = TOP_DIGIT;
                        state_in = S_BLANK;
                     end
                  end
                  OP_RANGE: begin
                     rsp_in.reg_address = REG_LEDS;
                     rsp_in.last        = 1'b1;
                     case (req_data.value)
                        32'sd0: begin
                           rsp_in.reg_data = LED_HZ;
                           strobe_in       = 1'b1;
                        end
                        32'sd1: begin
                           rsp_in.reg_data = LED_KHZ;
                           strobe_in       = 1'b1;
                        end
                        32'sd2: begin
                           rsp_in.reg_data = LED_MHZ;
                           strobe_in       = 1'b1;
                        end
                        default: begin
                           help_in  = 1'b1;
                           idx_in   = TOP_DIGIT;
                           state_in = S_BLANK;
                        end
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         S_INIT: begin
            strobe_in   = 1'b1;
            rsp_in.last = (k_ff == 2'd3);
            unique case (k_ff)
               2'd0: begin
                  rsp_in.reg_address = REG_DECODE;
                  rsp_in.reg_data    = DATA_DECODE;
               end
               2'd1: begin
                  rsp_in.reg_address = REG_SCANLIM;
                  rsp_in.reg_data    = DATA_SCANLIM;
               end
               2'd2: begin
                  rsp_in.reg_address = REG_INTENSITY;
                  rsp_in.reg_data    = {4'd0, intensity_ff};
               end
               default: begin
                  rsp_in.reg_address = REG_POWER;
                  rsp_in.reg_data    = DATA_POWER;
               end
            endcase
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = S_IDLE;
            end
         end
         S_CONV: begin
            if (conv_sts.done) begin
               idx_in   = TOP_DIGIT;
               state_in = S_BLANK;
            end
         end
         S_BLANK: begin
            strobe_in          = 1'b1;
            rsp_in.reg_address = idx_ff;
            rsp_in.reg_data    = {4'd0, CODE_BLANK};
            rsp_in.last        = 1'b0;
            idx_in             = idx_ff - 4'd1;
            if (idx_ff == 4'd1) begin
               if (help_ff) begin
                  k_in     = HELP_FIRST;
                  state_in = S_HELP;
               end else begin
                  idx_in   = TOP_DIGIT;
                  state_in = S_DIGIT;
               end
            end
         end
         S_DIGIT: begin
            strobe_in          = 1'b1;
            conv_ctl.pop       = 1'b1;
            rsp_in.reg_address = idx_ff;
            rsp_in.reg_data    = {4'd0, conv_sts.digit};
            // leading zeros stay blank: stop once the remaining BCD digits are zero
            rsp_in.last        = conv_sts.rest_zero || (idx_ff == 4'd1);
            idx_in             = idx_ff - 4'd1;
            if (conv_sts.rest_zero || (idx_ff == 4'd1)) begin
               state_in = S_IDLE;
            end
         end
         S_HELP: begin
            strobe_in          = 1'b1;
            rsp_in.reg_address = HELP_BASE + {2'd0, k_ff};
            rsp_in.reg_data    = {4'd0, help_code(k_ff)};
            rsp_in.last        = (k_ff == 2'd3);
            k_in               = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         help_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         help_ff   <= help_in;
      end
      idx_ff <= idx_in;
      k_ff   <= k_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         intensity_ff <= INTENSITY_RESET;
      end else if (csr_valid && csr_ready) begin
         intensity_ff <= csr_data;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* hdl/ddfg_checker.sv */
module ddfg_checker
   import ddfg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // the final word of a run coincides with the block going idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> !busy)
      else $error("last word while still busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy)
      else $error("run ended without a last word");

   // the first initialize word follows in the cycle after the block turns busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.operation == OP_INIT |=> busy ##1 rsp_strobe)
      else $error("initialize run did not start");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.reg_address != 4'd0)
      else $error("word to the no-op register");

endmodule

bind decimal_display_frame_generator_top ddfg_checker u_checker (.*);
